// ===== sv/mmf_pkg.sv =====
`timescale 1ns / 1ps

package mmf_pkg;

  // Request codes carried on the func field.
  localparam logic [2:0] FN_WRITE = 3'd0;
  localparam logic [2:0] FN_READ  = 3'd1;
  localparam logic [2:0] FN_FREE  = 3'd2;
  localparam logic [2:0] FN_VALID = 3'd3;
  localparam logic [2:0] FN_RESET = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_CREATED = 3'd1;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd2;
  localparam logic [2:0] ST_CORRUPT     = 3'd3;
  localparam logic [2:0] ST_NO_ROOM     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CREATED = 3'd0;
  localparam logic [2:0] CFG_CHCOUNT = 3'd1;
  localparam logic [2:0] CFG_DEPTH0  = 3'd2;
  localparam logic [2:0] CFG_DEPTH3  = 3'd5;

  localparam int DEPTH_REGS = 4;
  localparam int DEPTH_W    = 9;
  localparam int COUNT_W    = 8;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } mmf_state_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
  } mmf_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_burst;
    logic rd_left;
    logic q_valid;
    logic q_move;
  } mmf_sts_t;

endpackage

// ===== sv/mmf_ctrl.sv =====
`timescale 1ns / 1ps

module mmf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mmf_pkg::mmf_sts_t sts,
  output mmf_pkg::mmf_cmd_t cmd
);
  import mmf_pkg::*;

  mmf_state_t state;
  mmf_state_t state_next;

  always_comb begin
    state_next   = state;
    req_stall    = 1'b1;
    cmd.accept   = 1'b0;
    cmd.rd_issue = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall  = !sts.out_free;
        cmd.accept = req_valid && sts.out_free;
        if (cmd.accept && sts.is_burst) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = sts.rd_left && (!sts.q_valid || sts.q_move);
        if (!sts.rd_left && !sts.q_valid) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/mmf_dp.sv =====
`timescale 1ns / 1ps

module mmf_dp #(
  parameter int CHANNELS       = 4,
  parameter int MAX_DEPTH      = 256,
  parameter int ITEM_WIDTH     = 64,
  parameter int MAX_READ_BURST = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [8:0]            cfg_data,
  input  logic [2:0]            func,
  input  logic [3:0]            channel,
  input  logic [7:0]            item_count,
  input  logic                  group_first,
  input  logic                  group_last,
  input  logic [ITEM_WIDTH-1:0] item_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [2:0]            status,
  output logic [7:0]            count,
  output logic [ITEM_WIDTH-1:0] read_data,
  output logic                  last,
  input  mmf_pkg::mmf_cmd_t     cmd,
  output mmf_pkg::mmf_sts_t     sts
);
  import mmf_pkg::*;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W     = (PTR_W + 1 > DEPTH_W) ? PTR_W + 1 : DEPTH_W;
  localparam int AW        = CH_W + PTR_W;
  localparam int MEM_DEPTH = 2 ** AW;

  // Configuration.
  logic               created;
  logic [2:0]         chan_count;
  logic [DEPTH_W-1:0] depth_reg [DEPTH_REGS];

  // Ring pointers.
  logic [PTR_W-1:0] wp [CHANNELS];
  logic [PTR_W-1:0] rp [CHANNELS];

  // Open write group.
  logic               grp_open;
  logic [7:0]         grp_offset;
  logic [7:0]         grp_total;
  logic [CH_W-1:0]    grp_chan;
  logic [PTR_W-1:0]   grp_slot;
  logic [DEPTH_W-1:0] grp_depth;

  // Read burst.
  logic [CH_W-1:0]    rd_chan;
  logic [PTR_W-1:0]   rd_slot;
  logic [DEPTH_W-1:0] rd_depth;
  logic [7:0]         rd_left;
  logic [7:0]         rd_total;
  logic               q_valid;
  logic               q_last;
  logic [ITEM_WIDTH-1:0] q_data;

  logic [ITEM_WIDTH-1:0] ring [MEM_DEPTH];

  logic [CH_W-1:0]    ci;
  logic [DEPTH_W-1:0] d_c;
  logic [CNT_W-1:0]   dx, wx, rx, nx, valid_c, free_c, m_wide, rp_sum;
  logic [2:0]         chk;
  logic [7:0]         m8;
  logic [CH_W-1:0]    wr_chan;
  logic [PTR_W-1:0]   wr_slot;
  logic [DEPTH_W-1:0] wr_depth;
  logic [PTR_W-1:0]   slot_inc;
  logic [PTR_W:0]     slot_p1;
  logic [7:0]         off_new;
  logic [7:0]         tot_new;
  logic               is_wr, first_ok, do_store, commit;
  logic [PTR_W-1:0]   rd_inc;
  logic [PTR_W:0]     rd_p1;
  logic               need_res;
  logic [2:0]         res_status;
  logic [CNT_W-1:0]   res_count;
  logic               cfg_hit;

  assign ci = channel[CH_W-1:0];

  always_comb begin
    if (channel < 4'(DEPTH_REGS)) begin
      d_c = depth_reg[channel[1:0]];
    end else begin
      d_c = '0;
    end
    dx = CNT_W'(d_c);
    wx = CNT_W'(wp[ci]);
    rx = CNT_W'(rp[ci]);
    nx = CNT_W'(item_count);
    if (!created) begin
      chk = ST_NOT_CREATED;
    end else if (channel >= {1'b0, chan_count} || {1'b0, channel} >= 5'(CHANNELS)) begin
      chk = ST_BAD_CHANNEL;
    end else if (d_c == '0 || dx > CNT_W'(MAX_DEPTH) || wx >= dx || rx >= dx) begin
      chk = ST_CORRUPT;
    end else begin
      chk = ST_OK;
    end
    valid_c = (wx >= rx) ? (wx - rx) : (dx - rx + wx);
    free_c  = ((wx >= rx) ? (dx - wx + rx) : (rx - wx)) - CNT_W'(1);
    m_wide  = (nx < valid_c) ? nx : valid_c;
    if (m_wide > CNT_W'(MAX_READ_BURST)) begin
      m_wide = CNT_W'(MAX_READ_BURST);
    end
    m8 = m_wide[7:0];
    rp_sum = rx + m_wide;
    if (rp_sum >= dx) begin
      rp_sum = rp_sum - dx;
    end
  end

  // Write path: the first word of a group targets the write pointer, later
  // words follow the running slot of the open group.
  always_comb begin
    is_wr    = cmd.accept && (func == FN_WRITE);
    first_ok = (chk == ST_OK) && (nx <= free_c) && (item_count != 8'd0);
    wr_chan  = group_first ? ci : grp_chan;
    wr_slot  = group_first ? wp[ci] : grp_slot;
    wr_depth = group_first ? d_c : grp_depth;
    off_new  = group_first ? 8'd1 : grp_offset + 8'd1;
    tot_new  = group_first ? item_count : grp_total;
    do_store = is_wr && (group_first ? first_ok : grp_open);
    commit   = do_store && (off_new >= tot_new || group_last);
    slot_p1  = {1'b0, wr_slot} + (PTR_W + 1)'(1);
    if (CNT_W'(slot_p1) == CNT_W'(wr_depth)) begin
      slot_inc = '0;
    end else begin
      slot_inc = slot_p1[PTR_W-1:0];
    end
    rd_p1 = {1'b0, rd_slot} + (PTR_W + 1)'(1);
    if (CNT_W'(rd_p1) == CNT_W'(rd_depth)) begin
      rd_inc = '0;
    end else begin
      rd_inc = rd_p1[PTR_W-1:0];
    end
  end

  // Result, if one is due, of the accepted request.
  always_comb begin
    need_res   = 1'b0;
    res_status = ST_OK;
    res_count  = '0;
    case (func)
      FN_WRITE: begin
        if (group_first) begin
          need_res = !do_store || commit;
          if (chk != ST_OK) begin
            res_status = chk;
          end else if (nx > free_c) begin
            res_status = ST_NO_ROOM;
          end else if (commit) begin
            res_count = CNT_W'(off_new);
          end
        end else begin
          need_res  = commit;
          res_count = CNT_W'(off_new);
        end
      end
      FN_READ: begin
        need_res   = (chk != ST_OK) || (m8 == 8'd0);
        res_status = chk;
      end
      FN_FREE, FN_VALID: begin
        need_res   = 1'b1;
        res_status = chk;
        if (chk == ST_OK) begin
          res_count = (func == FN_FREE) ? free_c : valid_c;
        end
      end
      FN_RESET: begin
        need_res   = 1'b1;
        res_status = chk;
      end
      default: begin
        need_res = 1'b0;
      end
    endcase
  end

  assign sts.out_free = !rsp_valid || !rsp_stall;
  assign sts.is_burst = (func == FN_READ) && (chk == ST_OK) && (m8 != 8'd0);
  assign sts.rd_left  = (rd_left != 8'd0);
  assign sts.q_valid  = q_valid;
  assign sts.q_move   = q_valid && sts.out_free;

  assign cfg_hit = cfg_valid && (cfg_index <= CFG_DEPTH3);

  always_ff @(posedge clk) begin
    if (rst) begin
      created    <= 1'b0;
      chan_count <= '0;
      for (int i = 0; i < DEPTH_REGS; i++) begin
        depth_reg[i] <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        wp[i] <= '0;
        rp[i] <= '0;
      end
      grp_open   <= 1'b0;
      grp_offset <= '0;
      rd_left    <= '0;
      q_valid    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_hit) begin
        case (cfg_index)
          CFG_CREATED: created    <= cfg_data[0];
          CFG_CHCOUNT: chan_count <= cfg_data[2:0];
          default:     depth_reg[2'(cfg_index - CFG_DEPTH0)] <= cfg_data;
        endcase
        grp_open   <= 1'b0;
        grp_offset <= '0;
      end

      if (is_wr && group_first) begin
        grp_open   <= 1'b0;
        grp_offset <= '0;
      end
      if (do_store) begin
        grp_open   <= !commit;
        grp_offset <= commit ? 8'd0 : off_new;
        grp_slot   <= slot_inc;
        if (group_first) begin
          grp_chan  <= ci;
          grp_total <= item_count;
          grp_depth <= d_c;
        end
        if (commit) begin
          wp[wr_chan] <= slot_inc;
        end
      end

      if (cmd.accept && func == FN_RESET && chk == ST_OK) begin
        wp[ci]     <= '0;
        rp[ci]     <= '0;
        grp_open   <= 1'b0;
        grp_offset <= '0;
      end

      if (cmd.accept && sts.is_burst) begin
        rp[ci]   <= rp_sum[PTR_W-1:0];
        rd_chan  <= ci;
        rd_slot  <= rp[ci];
        rd_depth <= d_c;
        rd_left  <= m8;
        rd_total <= m8;
      end else if (cmd.rd_issue) begin
        rd_slot <= rd_inc;
        rd_left <= rd_left - 8'd1;
      end

      if (cmd.rd_issue) begin
        q_valid <= 1'b1;
        q_last  <= (rd_left == 8'd1);
      end else if (sts.q_move) begin
        q_valid <= 1'b0;
      end

      if (sts.q_move) begin
        rsp_valid <= 1'b1;
        status    <= ST_OK;
        count     <= rd_total;
        read_data <= q_data;
        last      <= q_last;
      end else if (cmd.accept && need_res) begin
        rsp_valid <= 1'b1;
        status    <= res_status;
        count     <= (res_count > CNT_W'(255)) ? 8'd255 : res_count[7:0];
        read_data <= '0;
        last      <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_store) begin
      ring[{wr_chan, wr_slot}] <= item_data;
    end
    if (cmd.rd_issue) begin
      q_data <= ring[{rd_chan, rd_slot}];
    end
  end

endmodule

// ===== sv/multichannel_mailbox_fifo.sv =====
`timescale 1ns / 1ps

// Multichannel mailbox: CHANNELS ring buffers of ITEM_WIDTH-bit words sharing
// one on-chip store, each channel owning a region of 2**clog2(MAX_DEPTH)
// words, and each holding at most depth-1 words. A write word, a query or a
// channel reset is taken while no read burst runs and the result register is
// free or is being emptied in that cycle. A read request that finds m words
// (m = min(valid, requested, MAX_READ_BURST)) holds off new requests until
// its last word has moved on to the result register: the store's single
// registered read port delivers one word per cycle, and downstream stall
// stretches this. Configuration writes are taken at any time but must only
// be issued while the block is idle. After reset no clearing pass is run;
// store words read before being written are undefined.
module multichannel_mailbox_fifo #(
  parameter int CHANNELS       = 4,
  parameter int MAX_DEPTH      = 256,
  parameter int ITEM_WIDTH     = 64,
  parameter int MAX_READ_BURST = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [8:0]            cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [2:0]            func,
  input  logic [3:0]            channel,
  input  logic [7:0]            item_count,
  input  logic                  group_first,
  input  logic                  group_last,
  input  logic [ITEM_WIDTH-1:0] item_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [2:0]            status,
  output logic [7:0]            count,
  output logic [ITEM_WIDTH-1:0] read_data,
  output logic                  last
);
  import mmf_pkg::*;

  mmf_cmd_t cmd;
  mmf_sts_t sts;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  // The controller sequences request acceptance and read bursts.
  mmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the registers, pointers, ring store and result register.
  mmf_dp #(
    .CHANNELS       (CHANNELS),
    .MAX_DEPTH      (MAX_DEPTH),
    .ITEM_WIDTH     (ITEM_WIDTH),
    .MAX_READ_BURST (MAX_READ_BURST)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .channel     (channel),
    .item_count  (item_count),
    .group_first (group_first),
    .group_last  (group_last),
    .item_data   (item_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .count       (count),
    .read_data   (read_data),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts)
  );

`ifndef ASSERT_OFF
  // While a burst still has words to fetch, no new request may enter.
  a_burst_blocks: assert property (@(posedge clk) disable iff (rst)
    sts.rd_left |-> req_stall)
    else $error("request accepted during a read burst");

  // A word fetched from the store is held until the result register takes it.
  a_issue_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> sts.q_valid)
    else $error("fetched word lost");

  // Error results never carry payload.
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> read_data == '0 && count == 8'd0)
    else $error("error result carries data");

  // A fetch is only issued while the controller has a burst in progress.
  a_issue_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> !cmd.accept)
    else $error("fetch issued while taking requests");
`endif

endmodule
